// File: rtl/fifo_queue_with_search_assert.svh
// Assertion macros shared by the queue checker.
// No dependencies.
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH

// clocked check, held off while reset is high
`define FQS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also applies during reset
`define FQS_ASSERT_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/fqs_pkg.sv
// Shared types and codes for the FIFO queue with membership search.
// No dependencies.
package fqs_pkg;

   localparam int DATA_W  = 32;
   localparam int FUNC_W  = 2;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 2;
   localparam int RSP_W   = 48;

   localparam logic [FUNC_W-1:0] FUNC_ENQ    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEQ    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [RSP_W-42:0]         pad;
      logic [STAT_W-1:0]         status;
      logic                      found;
      logic [COUNT_W-1:0]        entry_count;
      logic                      is_empty;
      logic signed [DATA_W-1:0]  head_value;
   } rsp_type;

endpackage

// File: rtl/fqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fifo_queue_with_search.sv
// FIFO queue of signed 32-bit values with enqueue, dequeue and membership search.
// Every request yields one response carrying the head value, empty flag, count,
// found flag and status. Enqueue, dequeue and unused codes pass through the execute,
// head-read and done states before the next acceptance; a search also scans the held
// entries, the single RAM read port feeding one compare per cycle. The entry store
// needs no clearing after reset. Depends on fqs_pkg and fqs_ram.
module fifo_queue_with_search
   import fqs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,   // [31:0] value
   input  logic [FUNC_W-1:0]   req_tuser,   // [1:0] func
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata    // [31:0] head_value, [32] is_empty,
                                            // [37:33] entry_count, [38] found,
                                            // [40:39] status, [47:41] zero
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_HEAD, S_DONE} state_type;

   state_type           state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [ADDR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                found_ff, found_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   tail;
   logic [CNT_W:0]      tail_sum;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [DATA_W-1:0]   rd_data;
   logic [31:0]         occ_ext;
   logic                hit;

   function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] i);
      return (i == ADDR_W'(DEPTH - 1)) ? '0 : i + ADDR_W'(1);
   endfunction

   assign tail_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(occ_ff);
   assign tail     = (tail_sum >= (CNT_W+1)'(DEPTH)) ?
                     ADDR_W'(tail_sum - (CNT_W+1)'(DEPTH)) : ADDR_W'(tail_sum);
   assign occ_ext  = 32'(occ_ff);
   assign hit      = (rd_data == value_ff);

   assign wr_en   = (state_ff == S_EXEC) && (func_ff == FUNC_ENQ) &&
                    (occ_ff != CNT_W'(DEPTH));
   assign rd_en   = (state_ff == S_EXEC) || (state_ff == S_SCAN) || (state_ff == S_HEAD);
   assign rd_addr = (state_ff == S_SCAN) ? idx_ff : head_ff;

   fqs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      value_in     = value_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in   = req_tuser;
               value_in  = req_tdata;
               found_in  = 1'b0;
               status_in = ST_OK;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_HEAD;
            case (func_ff)
               FUNC_ENQ: begin
                  if (occ_ff == CNT_W'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     occ_in = occ_ff + CNT_W'(1);
                  end
               end
               FUNC_DEQ: begin
                  if (occ_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     head_in = wrap_inc(head_ff);
                     occ_in  = occ_ff - CNT_W'(1);
                  end
               end
               FUNC_SEARCH: begin
                  idx_in = wrap_inc(head_ff);
                  cnt_in = CNT_W'(1);
                  if (occ_ff != '0) begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            if (hit || (cnt_ff == occ_ff)) begin
               found_in = hit;
               state_in = S_HEAD;
            end else begin
               idx_in = wrap_inc(idx_ff);
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_HEAD: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in.pad         = '0;
               rsp_data_in.status      = status_ff;
               rsp_data_in.found       = found_ff;
               rsp_data_in.entry_count = occ_ext[COUNT_W-1:0];
               rsp_data_in.is_empty    = (occ_ff == '0);
               rsp_data_in.head_value  = (occ_ff == '0) ? '1 : rd_data;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      value_ff    <= value_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/fqs_checker.sv
// Port-level checks for the FIFO queue with search, bound to the top level.
// Depends on fqs_pkg and fifo_queue_with_search_assert.svh.
`include "fifo_queue_with_search_assert.svh"

module fqs_checker
   import fqs_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

`FQS_ASSERT_RST(a_rsp_idle_after_reset, reset |=> !rsp_tvalid, "response valid after reset")
`FQS_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
`FQS_ASSERT(a_empty_count, rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[37:33] == '0, "empty with nonzero count")
`FQS_ASSERT(a_empty_head, rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[31:0] == '1, "empty head not all ones")
`FQS_ASSERT(a_found_ok, rsp_tvalid && rsp_tdata[38] |-> rsp_tdata[40:39] == ST_OK && !rsp_tdata[32], "found on empty or error")

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: verif/tb.sv
// Self-checking testbench for fifo_queue_with_search: directed and random requests
// against a cycle-free mirror of the queue. Depends on fqs_pkg and the queue RTL.
module tb;
   import fqs_pkg::*;

   localparam int QDEPTH = 16;
   localparam int LIMIT = 5000;
   localparam int RANDOM_ITEMS = 1100;
   localparam int TAIL_CYCLES = 40;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   class queue_mirror;
      logic [DATA_W-1:0] slots[QDEPTH];
      int oldest;
      int held;
      rsp_type pending_rsps[$];
      int errors;
      int reported;

      function new();
         oldest = 0;
         held = 0;
         errors = 0;
         reported = 0;
      endfunction

      function void take_request(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] value);
         rsp_type r;
         r = '0;
         case (func)
            FUNC_ENQ: begin
               if (held >= QDEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  slots[(oldest + held) % QDEPTH] = value;
                  held++;
               end
            end
            FUNC_DEQ: begin
               if (held == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  oldest = (oldest + 1) % QDEPTH;
                  held--;
               end
            end
            FUNC_SEARCH: begin
               for (int k = 0; k < held; k++)
                  if (slots[(oldest + k) % QDEPTH] == value) r.found = 1'b1;
            end
            default: ;
         endcase
         r.head_value = (held == 0) ? '1 : slots[oldest];
         r.is_empty = (held == 0);
         r.entry_count = held[COUNT_W-1:0];
         pending_rsps.push_back(r);
      endfunction

      function void note_error(string what, rsp_type exp_r, rsp_type got);
         errors++;
         if (reported < 10) begin
            reported++;
            $display("MISMATCH %s: exp head=%0d empty=%0d count=%0d found=%0d status=%0d pad=%0h",
                     what, $signed(exp_r.head_value), exp_r.is_empty, exp_r.entry_count,
                     exp_r.found, exp_r.status, exp_r.pad);
            $display("            got head=%0d empty=%0d count=%0d found=%0d status=%0d pad=%0h",
                     $signed(got.head_value), got.is_empty, got.entry_count,
                     got.found, got.status, got.pad);
         end
      endfunction

      function void match_response(rsp_type got);
         rsp_type exp_r;
         if (pending_rsps.size() == 0) begin
            note_error("unexpected response", '0, got);
            return;
         end
         exp_r = pending_rsps.pop_front();
         if (got.head_value !== exp_r.head_value || got.is_empty !== exp_r.is_empty ||
             got.entry_count !== exp_r.entry_count || got.found !== exp_r.found ||
             got.status !== exp_r.status || got.pad !== exp_r.pad)
            note_error("response", exp_r, got);
      endfunction

      function int pending();
         return pending_rsps.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0] req_tuser = FUNC_ENQ;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   queue_mirror mirror = new();
   int stall_cycles = 0;
   logic [DATA_W-1:0] recent_vals[QDEPTH];
   int recent_wr = 0;
   int burst_left = 0;
   int rdy_run = 0;
   int rdy_mode = 0;
   int rdy_tick = 0;

   fifo_queue_with_search #(.DEPTH(QDEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         stall_cycles++;
         if (req_tvalid && req_tready) begin
            mirror.take_request(req_tuser, req_tdata);
            stall_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            mirror.match_response(rsp_type'(rsp_tdata));
            stall_cycles = 0;
         end
         if (stall_cycles >= LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (rdy_run == 0) begin
         rdy_mode = $urandom_range(0, 3);
         rdy_run = $urandom_range(20, 200);
      end
      rdy_run--;
      rdy_tick++;
      case (rdy_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (rdy_tick % 7) > 2;
         default: rsp_tready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   task automatic send_req(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] value);
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tuser <= func;
      if (func == FUNC_ENQ) begin
         recent_vals[recent_wr] = value;
         recent_wr = (recent_wr + 1) % QDEPTH;
      end
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic idle(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (mirror.pending() != 0);
   endtask

   task automatic pace();
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 30));
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
   endtask

   function automatic logic [DATA_W-1:0] pick_value(input bit prefer_recent);
      int r;
      r = $urandom_range(0, 99);
      if (prefer_recent && r < 50) return recent_vals[$urandom_range(0, QDEPTH - 1)];
      if (r < 15) begin
         case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return 32'h0000_0001;
         endcase
      end
      if (r < 35) return $urandom_range(0, 7);
      return $urandom;
   endfunction

   initial begin
      int phase;
      int phase_left;
      int r;
      logic [FUNC_W-1:0] func;
      phase = 0;
      phase_left = 0;
      for (int i = 0; i < QDEPTH; i++) recent_vals[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_req(FUNC_SEARCH, 32'h0000_0000);
      send_req(FUNC_DEQ, 32'h0000_0000);
      send_req(FUNC_UNUSED, 32'hffff_ffff);
      send_req(FUNC_ENQ, 32'h8000_0000);
      send_req(FUNC_ENQ, 32'h7fff_ffff);
      send_req(FUNC_ENQ, 32'hffff_ffff);
      send_req(FUNC_ENQ, 32'h0000_0000);
      send_req(FUNC_SEARCH, 32'h7fff_ffff);
      send_req(FUNC_SEARCH, 32'h7fff_fffe);
      send_req(FUNC_SEARCH, 32'hffff_ffff);
      send_req(FUNC_UNUSED, 32'h0000_0000);
      send_req(FUNC_DEQ, 32'h0000_0000);
      for (int i = 0; i < 13; i++) send_req(FUNC_ENQ, $urandom);
      send_req(FUNC_ENQ, 32'h1234_5678);
      send_req(FUNC_SEARCH, recent_vals[(recent_wr + QDEPTH - 2) % QDEPTH]);
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            phase = $urandom_range(0, 3);
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;
         r = $urandom_range(0, 99);
         case (phase)
            0: func = (r < 65) ? FUNC_ENQ : (r < 80) ? FUNC_DEQ : FUNC_SEARCH;
            1: func = (r < 20) ? FUNC_ENQ : (r < 75) ? FUNC_DEQ : FUNC_SEARCH;
            2: func = (r < 40) ? FUNC_ENQ : (r < 70) ? FUNC_DEQ : FUNC_SEARCH;
            default: func = (r < 25) ? FUNC_ENQ : (r < 40) ? FUNC_DEQ : FUNC_SEARCH;
         endcase
         if (r >= 97) func = FUNC_UNUSED;
         if (n == RANDOM_ITEMS / 2) drain();
         pace();
         send_req(func, pick_value(func == FUNC_SEARCH));
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mirror.errors == 0 && mirror.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/fqs_pkg.sv
rtl/fqs_ram.sv
rtl/fifo_queue_with_search.sv
rtl/fqs_checker.sv
verif/tb.sv
